// ===== rtl/core/isop_pkg.sv =====
// isop_pkg: shared constants, types and codes for isolated point removal
// used by every module under rtl/core but isop_fifo; depends on nothing

package isop_pkg;

    // default coordinate width, fixed field widths, reset limit, queue depth
    localparam int COORD_BITS_DEF  = 16;
    localparam int IDX_W           = 16;
    localparam int CFG_W           = 16;
    localparam int LIM_W           = 2 * CFG_W;
    localparam int MAX_DIST_RESET  = 500;
    localparam int QUEUE_DEPTH_DEF = 4;

    // squared limit after reset
    localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(MAX_DIST_RESET * MAX_DIST_RESET);

    // how far the current scan has filled
    typedef enum logic [1:0] {
        FILL_EMPTY,
        FILL_ONE,
        FILL_MANY
    } fill_t;

    // which verdicts one queued entry carries, and their kept flags
    typedef struct packed {
        logic emit_prev;
        logic emit_cur;
        logic emit_first;
        logic keep_prev;
        logic keep_cur;
        logic keep_first;
    } isop_flags_t;

    localparam int FLAG_W = $bits(isop_flags_t);

endpackage

// ===== rtl/core/isop_fifo.sv =====
// isop_fifo: small register queue between the classifying front and the output back
// depends on nothing; width and depth come from the instantiating module

module isop_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = PTR_W + 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    // status
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/isop_front.sv =====
// isop_front: accepts scan points, squares neighbor distances in two stages and
// classifies each point into queued verdicts; depends on isop_pkg

module isop_front #(
    parameter int COORD_BITS = isop_pkg::COORD_BITS_DEF,
    parameter int ENTRY_W    = 6 * COORD_BITS + isop_pkg::IDX_W + isop_pkg::FLAG_W
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [COORD_BITS-1:0]   s_point_x,
    input  logic signed [COORD_BITS-1:0]   s_point_y,
    input  logic                           s_last_in_scan,
    input  logic [isop_pkg::LIM_W-1:0]     lim,
    output logic                           q_push,
    output logic [ENTRY_W-1:0]             q_data,
    input  logic                           q_full
);

    import isop_pkg::*;

    localparam int CB     = COORD_BITS;
    localparam int SQ_W   = 2 * CB;
    localparam int DIST_W = SQ_W + 1;
    localparam int CMP_W  = (DIST_W > LIM_W) ? DIST_W : LIM_W;

    // scan state seen at the input
    fill_t           fill_reg;
    logic [IDX_W-1:0] pts_reg;
    logic [CB-1:0]   first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;

    // stage 1: absolute differences
    logic            s1_valid_reg;
    fill_t           s1_fill_reg;
    logic            s1_last_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic [CB-1:0]   s1_x_reg, s1_y_reg, s1_px_reg, s1_py_reg, s1_fx_reg, s1_fy_reg;
    logic [CB-1:0]   s1_adxb_reg, s1_adyb_reg, s1_adxw_reg, s1_adyw_reg;

    // stage 2: squares
    logic            s2_valid_reg;
    fill_t           s2_fill_reg;
    logic            s2_last_reg;
    logic [IDX_W-1:0] s2_idx_reg;
    logic [CB-1:0]   s2_x_reg, s2_y_reg, s2_px_reg, s2_py_reg, s2_fx_reg, s2_fy_reg;
    logic [SQ_W-1:0] s2_sqxb_reg, s2_sqyb_reg, s2_sqxw_reg, s2_sqyw_reg;

    // distances kept across points of a scan
    logic [DIST_W-1:0] prev_back_reg, first_fwd_reg;

    logic              en, accept;
    logic signed [CB:0] dxb, dyb, dxw, dyw;
    logic [CB:0]       axb, ayb, axw, ayw;
    logic [DIST_W-1:0] back_dist, wrap_dist;
    logic              back_lt, wrap_lt, prev_lt, first_lt;
    isop_flags_t       flags;
    logic [IDX_W-1:0]  prev_idx;

    // the whole front moves unless a finished entry waits on a full queue
    assign en      = !s2_valid_reg || !q_full;
    assign s_ready = en;
    assign accept  = s_valid && en;

    // signed differences to the previous and to the first point
    assign dxb = $signed({s_point_x[CB-1], s_point_x}) - $signed({prev_x_reg[CB-1], prev_x_reg});
    assign dyb = $signed({s_point_y[CB-1], s_point_y}) - $signed({prev_y_reg[CB-1], prev_y_reg});
    assign dxw = $signed({s_point_x[CB-1], s_point_x}) - $signed({first_x_reg[CB-1], first_x_reg});
    assign dyw = $signed({s_point_y[CB-1], s_point_y}) - $signed({first_y_reg[CB-1], first_y_reg});

    // magnitudes, which fit in CB bits
    assign axb = dxb[CB] ? (~dxb + 1'b1) : dxb;
    assign ayb = dyb[CB] ? (~dyb + 1'b1) : dyb;
    assign axw = dxw[CB] ? (~dxw + 1'b1) : dxw;
    assign ayw = dyw[CB] ? (~dyw + 1'b1) : dyw;

    // scan bookkeeping at each input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= FILL_EMPTY;
            pts_reg     <= '0;
            first_x_reg <= '0;
            first_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
        end else if (accept) begin
            prev_x_reg <= s_point_x;
            prev_y_reg <= s_point_y;
            if (fill_reg == FILL_EMPTY) begin
                first_x_reg <= s_point_x;
                first_y_reg <= s_point_y;
            end
            if (s_last_in_scan) begin
                fill_reg <= FILL_EMPTY;
                pts_reg  <= '0;
            end else begin
                fill_reg <= (fill_reg == FILL_EMPTY) ? FILL_ONE : FILL_MANY;
                pts_reg  <= pts_reg + 1'b1;
            end
        end
    end

    // stage 1 registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_fill_reg <= fill_reg;
            s1_last_reg <= s_last_in_scan;
            s1_idx_reg  <= pts_reg;
            s1_x_reg    <= s_point_x;
            s1_y_reg    <= s_point_y;
            s1_px_reg   <= prev_x_reg;
            s1_py_reg   <= prev_y_reg;
            s1_fx_reg   <= (fill_reg == FILL_EMPTY) ? s_point_x : first_x_reg;
            s1_fy_reg   <= (fill_reg == FILL_EMPTY) ? s_point_y : first_y_reg;
            s1_adxb_reg <= axb[CB-1:0];
            s1_adyb_reg <= ayb[CB-1:0];
            s1_adxw_reg <= axw[CB-1:0];
            s1_adyw_reg <= ayw[CB-1:0];
        end
    end

    // stage 2 registers: one multiplier per square
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_fill_reg <= s1_fill_reg;
            s2_last_reg <= s1_last_reg;
            s2_idx_reg  <= s1_idx_reg;
            s2_x_reg    <= s1_x_reg;
            s2_y_reg    <= s1_y_reg;
            s2_px_reg   <= s1_px_reg;
            s2_py_reg   <= s1_py_reg;
            s2_fx_reg   <= s1_fx_reg;
            s2_fy_reg   <= s1_fy_reg;
            s2_sqxb_reg <= SQ_W'(s1_adxb_reg) * SQ_W'(s1_adxb_reg);
            s2_sqyb_reg <= SQ_W'(s1_adyb_reg) * SQ_W'(s1_adyb_reg);
            s2_sqxw_reg <= SQ_W'(s1_adxw_reg) * SQ_W'(s1_adxw_reg);
            s2_sqyw_reg <= SQ_W'(s1_adyw_reg) * SQ_W'(s1_adyw_reg);
        end
    end

    // distances and comparisons against the squared limit
    assign back_dist = DIST_W'(s2_sqxb_reg) + DIST_W'(s2_sqyb_reg);
    assign wrap_dist = DIST_W'(s2_sqxw_reg) + DIST_W'(s2_sqyw_reg);
    assign back_lt   = CMP_W'(back_dist) < CMP_W'(lim);
    assign wrap_lt   = CMP_W'(wrap_dist) < CMP_W'(lim);
    assign prev_lt   = CMP_W'(prev_back_reg) < CMP_W'(lim);
    assign first_lt  = CMP_W'(first_fwd_reg) < CMP_W'(lim);
    assign prev_idx  = s2_idx_reg - 1'b1;

    // classify the point into the verdicts it releases
    always_comb begin
        flags = '0;
        case (s2_fill_reg)
            FILL_EMPTY: begin
                flags.emit_first = s2_last_reg;
                flags.keep_first = (lim != '0);
            end
            FILL_ONE: begin
                flags.emit_cur   = s2_last_reg;
                flags.emit_first = s2_last_reg;
                flags.keep_cur   = back_lt || wrap_lt;
                flags.keep_first = back_lt || wrap_lt;
            end
            FILL_MANY: begin
                flags.emit_prev  = 1'b1;
                flags.emit_cur   = s2_last_reg;
                flags.emit_first = s2_last_reg;
                flags.keep_prev  = prev_lt || back_lt;
                flags.keep_cur   = back_lt || wrap_lt;
                flags.keep_first = first_lt || wrap_lt;
            end
            default: begin
                flags = '0;
            end
        endcase
    end

    // distances carried to the next point of the scan
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_back_reg <= '0;
            first_fwd_reg <= '0;
        end else if (s2_valid_reg && en) begin
            if (s2_fill_reg == FILL_ONE) begin
                first_fwd_reg <= back_dist;
            end
            if (s2_fill_reg != FILL_EMPTY) begin
                prev_back_reg <= back_dist;
            end
        end
    end

    // queue entry
    assign q_push = s2_valid_reg && en &&
                    (flags.emit_prev || flags.emit_cur || flags.emit_first);
    assign q_data = {s2_px_reg, s2_py_reg, s2_x_reg, s2_y_reg, s2_fx_reg, s2_fy_reg,
                     (flags.emit_prev ? prev_idx : s2_idx_reg), flags};

    // checks
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("front pushed into a full queue");

    a_first_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (fill_reg == FILL_EMPTY) |=> (fill_reg != FILL_MANY))
        else $error("scan skipped its second point");

    a_scan_close: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_last_in_scan |=> (fill_reg == FILL_EMPTY) && (pts_reg == '0))
        else $error("scan did not restart after its last point");

endmodule

// ===== rtl/core/isop_back.sv =====
// isop_back: takes queued entries and sends their verdicts one per transfer
// through a registered output; depends on isop_pkg

module isop_back #(
    parameter int COORD_BITS = isop_pkg::COORD_BITS_DEF,
    parameter int ENTRY_W    = 6 * COORD_BITS + isop_pkg::IDX_W + isop_pkg::FLAG_W
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [ENTRY_W-1:0]            q_head,
    input  logic                          q_empty,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_BITS-1:0]  m_out_x,
    output logic signed [COORD_BITS-1:0]  m_out_y,
    output logic [isop_pkg::IDX_W-1:0]    m_point_index,
    output logic                          m_kept,
    output logic                          m_end_of_scan
);

    import isop_pkg::*;

    localparam int CB = COORD_BITS;

    // entry layout, high to low: prev, cur, first coordinates, index, flags
    localparam int FY_LO  = FLAG_W + IDX_W;
    localparam int FX_LO  = FY_LO + CB;
    localparam int CY_LO  = FX_LO + CB;
    localparam int CX_LO  = CY_LO + CB;
    localparam int PY_LO  = CX_LO + CB;
    localparam int PX_LO  = PY_LO + CB;

    isop_flags_t      flags;
    logic [IDX_W-1:0] h_idx, cur_idx;
    logic [CB-1:0]    h_px, h_py, h_cx, h_cy, h_fx, h_fy;
    logic [2:0]       done_reg, done_next, pend, sel;
    logic             load;

    logic             m_valid_reg;
    logic [CB-1:0]    out_x_reg, out_y_reg, out_x_next, out_y_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             kept_reg, kept_next, end_reg, end_next;

    // unpack the queue head
    assign flags = isop_flags_t'(q_head[FLAG_W-1:0]);
    assign h_idx = q_head[FLAG_W +: IDX_W];
    assign h_fy  = q_head[FY_LO +: CB];
    assign h_fx  = q_head[FX_LO +: CB];
    assign h_cy  = q_head[CY_LO +: CB];
    assign h_cx  = q_head[CX_LO +: CB];
    assign h_py  = q_head[PY_LO +: CB];
    assign h_px  = q_head[PX_LO +: CB];

    // index field holds the previous point's index when that verdict is present
    assign cur_idx = flags.emit_prev ? h_idx + 1'b1 : h_idx;

    // verdicts of the head entry not yet sent: bit 0 prev, bit 1 cur, bit 2 first
    assign pend = {flags.emit_first, flags.emit_cur, flags.emit_prev} & ~done_reg;
    assign sel  = pend & (~pend + 1'b1);

    // load the output register if an entry waits and it is free or being drained
    assign load      = !q_empty && (!m_valid_reg || m_ready);
    assign q_pop     = load && ((pend & ~sel) == 3'b000);
    assign done_next = q_pop ? 3'b000 : (load ? (done_reg | sel) : done_reg);

    // pick the verdict in scan order
    always_comb begin
        out_x_next = h_fx;
        out_y_next = h_fy;
        idx_next   = '0;
        kept_next  = flags.keep_first;
        end_next   = 1'b1;
        if (pend[0]) begin
            out_x_next = h_px;
            out_y_next = h_py;
            idx_next   = h_idx;
            kept_next  = flags.keep_prev;
            end_next   = 1'b0;
        end else if (pend[1]) begin
            out_x_next = h_cx;
            out_y_next = h_cy;
            idx_next   = cur_idx;
            kept_next  = flags.keep_cur;
            end_next   = 1'b0;
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg    <= 3'b000;
            m_valid_reg <= 1'b0;
        end else begin
            done_reg <= done_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            out_x_reg <= out_x_next;
            out_y_reg <= out_y_next;
            idx_reg   <= idx_next;
            kept_reg  <= kept_next;
            end_reg   <= end_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_x       = out_x_reg;
    assign m_out_y       = out_y_reg;
    assign m_point_index = idx_reg;
    assign m_kept        = kept_reg;
    assign m_end_of_scan = end_reg;

    // checks
    a_head_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_empty |-> (pend != 3'b000))
        else $error("queue head has no verdict left to send");

    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        q_empty |-> (done_reg == 3'b000))
        else $error("sent-verdict mask left over with an empty queue");

    a_end_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && end_reg |-> (idx_reg == '0))
        else $error("end of scan verdict not for point zero");

endmodule

// ===== rtl/core/isolated_point_removal.sv =====
// isolated_point_removal: top level; holds the squared limit register and joins
// front, queue and back; depends on isop_pkg, isop_front, isop_fifo, isop_back
//
//   channel   handshake            payload
//   s_        s_valid / s_ready    s_point_x, s_point_y, s_last_in_scan
//   m_        m_valid / m_ready    m_out_x, m_out_y, m_point_index, m_kept, m_end_of_scan
//   cfg_      cfg_wr_en            cfg_wr_data (max_distance)
//
// one point is taken each cycle unless the front stalls; a point's verdict is classified
// after the difference and square registers, then passes the queue and output register
// a scan's last point releases up to three verdicts; the back sends one per cycle while
// m_ready is high, and the QUEUE_DEPTH-entry queue absorbs them as the front takes points
// reset is synchronous and active low, sets the limit to 500 and empties the scan
// the front stalls only when its finished entry meets a full queue

module isolated_point_removal #(
    parameter int COORD_BITS  = isop_pkg::COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = isop_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [isop_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_BITS-1:0]  s_point_x,
    input  logic signed [COORD_BITS-1:0]  s_point_y,
    input  logic                          s_last_in_scan,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_BITS-1:0]  m_out_x,
    output logic signed [COORD_BITS-1:0]  m_out_y,
    output logic [isop_pkg::IDX_W-1:0]    m_point_index,
    output logic                          m_kept,
    output logic                          m_end_of_scan
);

    import isop_pkg::*;

    localparam int ENTRY_W = 6 * COORD_BITS + IDX_W + FLAG_W;

    logic [LIM_W-1:0]   lim_reg;
    logic               q_push, q_full, q_pop, q_empty;
    logic [ENTRY_W-1:0] q_data, q_head;

    // squared limit, formed at the register write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_reg <= LIM_RESET;
        end else if (cfg_wr_en) begin
            lim_reg <= LIM_W'(cfg_wr_data) * LIM_W'(cfg_wr_data);
        end
    end

    // accept and classify
    isop_front #(
        .COORD_BITS (COORD_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_point_x      (s_point_x),
        .s_point_y      (s_point_y),
        .s_last_in_scan (s_last_in_scan),
        .lim            (lim_reg),
        .q_push         (q_push),
        .q_data         (q_data),
        .q_full         (q_full)
    );

    // decoupling queue
    isop_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    // verdict output
    isop_back #(
        .COORD_BITS (COORD_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_head        (q_head),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_x       (m_out_x),
        .m_out_y       (m_out_y),
        .m_point_index (m_point_index),
        .m_kept        (m_kept),
        .m_end_of_scan (m_end_of_scan)
    );

endmodule

// ===== dv/isolated_point_removal_tb.sv =====
// isolated_point_removal_tb: self-checking testbench for isolated_point_removal
// predicts every verdict of each circular scan and compares the m_ transfers in order
// depends on isop_pkg and isolated_point_removal

module isolated_point_removal_tb;

    import isop_pkg::*;

    localparam int CW = COORD_BITS_DEF;
    localparam int IW = IDX_W;
    localparam int DW = 2 * CW + 2;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [IW-1:0]        index;
        logic                 kept;
        logic                 scan_end;
    } verdict_t;

    // verdict predictor and in-order store of expected verdicts
    class verdict_scoreboard;
        logic signed [CW-1:0] first_x, first_y, last_x, last_y;
        logic [DW-1:0]        last_back_sq, first_fwd_sq;
        logic [IW-1:0]        seen;
        fill_t                fill;
        logic [LIM_W-1:0]     limit_sq;
        verdict_t             expected_verdicts[$];
        int                   failures;
        int                   points_noted;
        int                   scans_noted;
        int                   verdicts_checked;

        function new();
            first_x = '0; first_y = '0; last_x = '0; last_y = '0;
            last_back_sq = '0; first_fwd_sq = '0;
            seen = '0;
            fill = FILL_EMPTY;
            failures = 0; points_noted = 0; scans_noted = 0; verdicts_checked = 0;
            set_limit(CFG_W'(MAX_DIST_RESET));
        endfunction

        function void set_limit(logic [CFG_W-1:0] mm);
            limit_sq = LIM_W'(mm) * LIM_W'(mm);
        endfunction

        function logic [DW-1:0] dist_sq(logic signed [CW-1:0] ax, logic signed [CW-1:0] ay,
                                        logic signed [CW-1:0] bx, logic signed [CW-1:0] by);
            longint dx, dy;
            dx = longint'(ax) - longint'(bx);
            dy = longint'(ay) - longint'(by);
            return DW'(dx * dx + dy * dy);
        endfunction

        function void push_verdict(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                   logic [IW-1:0] index, logic kept, logic scan_end);
            verdict_t v;
            v.x = x; v.y = y; v.index = index; v.kept = kept; v.scan_end = scan_end;
            expected_verdicts.insert(expected_verdicts.size(), v);
        endfunction

        // accepted point: work out the verdicts it releases
        function void note_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y, logic last);
            logic [DW-1:0] back, wrap, lim;
            logic [IW-1:0] idx;
            lim = DW'(limit_sq);
            points_noted++;
            if (last)
                scans_noted++;
            if (fill == FILL_EMPTY) begin
                first_x = x; first_y = y; last_x = x; last_y = y;
                last_back_sq = '0; first_fwd_sq = '0;
                // single point scan is its own neighbor at distance zero
                if (last) begin
                    push_verdict(x, y, '0, limit_sq != '0, 1'b1);
                    seen = '0;
                end else begin
                    seen = IW'(1);
                    fill = FILL_ONE;
                end
                return;
            end
            idx = seen;
            back = dist_sq(x, y, last_x, last_y);
            if (fill == FILL_ONE)
                first_fwd_sq = back;
            else
                push_verdict(last_x, last_y, idx - IW'(1), last_back_sq < lim || back < lim,
                             1'b0);
            last_back_sq = back;
            last_x = x; last_y = y;
            fill = FILL_MANY;
            seen = seen + IW'(1);
            // closing point judges itself and point 0 through the wrap distance
            if (last) begin
                wrap = dist_sq(x, y, first_x, first_y);
                push_verdict(x, y, idx, back < lim || wrap < lim, 1'b0);
                push_verdict(first_x, first_y, '0, first_fwd_sq < lim || wrap < lim, 1'b1);
                seen = '0;
                fill = FILL_EMPTY;
            end
        endfunction

        // compare one m_ transfer with the oldest expected verdict
        function void check_verdict(verdict_t got);
            verdict_t exp_v;
            verdicts_checked++;
            if (expected_verdicts.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected verdict at %0t: x=%0d y=%0d idx=%0d kept=%0b end=%0b",
                             $time, got.x, got.y, got.index, got.kept, got.scan_end);
                return;
            end
            exp_v = expected_verdicts.pop_front();
            if (got.x !== exp_v.x || got.y !== exp_v.y || got.index !== exp_v.index ||
                got.kept !== exp_v.kept || got.scan_end !== exp_v.scan_end) begin
                failures++;
                if (failures <= 10)
                    $display({"mismatch at %0t: expected x=%0d y=%0d idx=%0d kept=%0b end=%0b,",
                              " got x=%0d y=%0d idx=%0d kept=%0b end=%0b"}, $time,
                             exp_v.x, exp_v.y, exp_v.index, exp_v.kept, exp_v.scan_end,
                             got.x, got.y, got.index, got.kept, got.scan_end);
            end
        endfunction

        function int pending_count();
            return expected_verdicts.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_W-1:0]      cfg_wr_data;
    logic                  s_valid;
    logic                  s_ready;
    logic signed [CW-1:0]  s_point_x;
    logic signed [CW-1:0]  s_point_y;
    logic                  s_last_in_scan;
    logic                  m_valid;
    logic                  m_ready;
    logic signed [CW-1:0]  m_out_x;
    logic signed [CW-1:0]  m_out_y;
    logic [IW-1:0]         m_point_index;
    logic                  m_kept;
    logic                  m_end_of_scan;

    verdict_scoreboard sb;
    bit                idle_on;
    int                limit_writes;

    isolated_point_removal DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_point_x      (s_point_x),
        .s_point_y      (s_point_y),
        .s_last_in_scan (s_last_in_scan),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_x        (m_out_x),
        .m_out_y        (m_out_y),
        .m_point_index  (m_point_index),
        .m_kept         (m_kept),
        .m_end_of_scan  (m_end_of_scan)
    );

    // clock
    always #10 aclk = ~aclk;

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // coordinate within span of base, wrapping at the field width
    function automatic logic signed [CW-1:0] near_coord(logic signed [CW-1:0] base, int span);
        int off;
        off = int'($urandom_range(0, 2 * span)) - span;
        return CW'(int'(base) + off);
    endfunction

    // one input transfer; entered and left at a falling edge
    task automatic send_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y, logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_point_x      <= x;
        s_point_y      <= y;
        s_last_in_scan <= last;
        s_valid        <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_point(x, y, last);
        @(negedge aclk);
    endtask

    // register write once the block has drained
    task automatic set_limit(int mm);
        s_valid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge aclk);
        // a point that releases nothing may still be in the pipeline
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CFG_W'(mm);
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_limit(CFG_W'(mm));
        limit_writes++;
    endtask

    function automatic int span_for(int mm);
        return (mm < 40000) ? mm + mm / 2 + 2 : 65535;
    endfunction

    // one scan: a walk around the limit with some far jumps
    task automatic send_scan(int len, int span);
        logic signed [CW-1:0] x, y;
        x = CW'($urandom);
        y = CW'($urandom);
        for (int i = 0; i < len; i++) begin
            if (i > 0) begin
                if ($urandom_range(0, 99) < 15) begin
                    x = CW'($urandom);
                    y = CW'($urandom);
                end else begin
                    x = near_coord(x, span);
                    y = near_coord(y, span);
                end
            end
            send_point(x, y, i == len - 1);
        end
    endtask

    // random scans at one limit
    task automatic run_phase(int mm, int n_items);
        int sent, len, r;
        sent = 0;
        set_limit(mm);
        while (sent < n_items) begin
            idle_on = ($urandom_range(0, 4) != 0);
            r = $urandom_range(0, 99);
            if (r < 15)
                len = 1;
            else if (r < 30)
                len = 2;
            else if (r < 85)
                len = $urandom_range(3, 10);
            else
                len = $urandom_range(11, 40);
            send_scan(len, span_for(mm));
            sent += len;
        end
        idle_on = 1'b1;
    endtask

    // result side ready pattern
    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
    end

    // check every result transfer
    always @(posedge aclk) begin
        verdict_t got;
        if (aresetn && m_valid && m_ready) begin
            got.x        = m_out_x;
            got.y        = m_out_y;
            got.index    = m_point_index;
            got.kept     = m_kept;
            got.scan_end = m_end_of_scan;
            sb.check_verdict(got);
        end
    end

    // main sequence
    initial begin
        sb             = new();
        idle_on        = 1'b1;
        limit_writes   = 0;
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_valid        = 1'b0;
        s_point_x      = '0;
        s_point_y      = '0;
        s_last_in_scan = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // limit after reset: single point, pair exactly at the limit, far corners
        send_point(16'sd0, 16'sd0, 1'b1);
        send_point(16'sd100, 16'sd100, 1'b0);
        send_point(16'sd400, 16'sd500, 1'b1);
        send_point(-16'sd32768, -16'sd32768, 1'b0);
        send_point(16'sd32767, 16'sd32767, 1'b0);
        send_point(-16'sd32768, 16'sd32767, 1'b1);

        // zero limit keeps nothing, not even coincident points
        set_limit(0);
        send_point(16'sd7, -16'sd7, 1'b1);
        send_point(16'sd9, 16'sd9, 1'b0);
        send_point(16'sd9, 16'sd9, 1'b1);

        // widest limit: full span is not strictly below, one less is
        set_limit(65535);
        send_point(-16'sd32768, 16'sd0, 1'b0);
        send_point(16'sd32767, 16'sd0, 1'b1);
        send_point(-16'sd32767, 16'sd0, 1'b0);
        send_point(16'sd32767, 16'sd0, 1'b0);
        send_point(16'sd32767, -16'sd32768, 1'b1);

        // unit limit: only coincident neighbors count
        set_limit(1);
        send_point(16'sd5, 16'sd5, 1'b0);
        send_point(16'sd5, 16'sd5, 1'b0);
        send_point(16'sd5, 16'sd6, 1'b0);
        send_point(16'sd7, 16'sd7, 1'b1);

        // random scans across limit settings
        run_phase($urandom_range(1, 200), 70);
        run_phase(500, 70);
        run_phase($urandom_range(1000, 20000), 70);
        run_phase(65535, 70);
        run_phase(0, 70);
        run_phase($urandom_range(0, 65535), 70);

        s_valid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        $display("covered %0d points in %0d scans over %0d limit writes, %0d verdicts checked",
                 sb.points_noted, sb.scans_noted, limit_writes, sb.verdicts_checked);
        $display("%0d failures, %0d verdicts never arrived", sb.failures, sb.pending_count());
        if (sb.failures == 0 && sb.pending_count() == 0)
            $display("isolated_point_removal test passed");
        else
            $display("isolated_point_removal test failed");
        $finish;
    end

    // run time limit
    initial begin
        #(20 * 1000000);
        $display("timeout with %0d verdicts outstanding", sb.pending_count());
        $display("isolated_point_removal test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/isop_pkg.sv
rtl/core/isop_fifo.sv
rtl/core/isop_front.sv
rtl/core/isop_back.sv
rtl/core/isolated_point_removal.sv
dv/isolated_point_removal_tb.sv
